@@ hw/rtl/tcphp_pkg.sv @@
// Shared types and constants for the TCP header field parser.
// No dependencies; imported by tcphp_opt_walk and tcp_header_field_parser.
`timescale 1ns / 1ps
`default_nettype none

package tcphp_pkg;

  localparam logic [5:0]  HDR_FIXED_BYTES = 6'd20;
  localparam logic [15:0] MSS_NONE        = 16'hFFFF;

  localparam logic [7:0] KIND_END = 8'd0;
  localparam logic [7:0] KIND_NOP = 8'd1;
  localparam logic [7:0] KIND_MSS = 8'd2;

  localparam logic [1:0] ST_HDR_END   = 2'd0;
  localparam logic [1:0] ST_EOL       = 2'd1;
  localparam logic [1:0] ST_UNKNOWN   = 2'd2;
  localparam logic [1:0] ST_MSS_TRUNC = 2'd3;

  typedef enum logic [2:0] {
    MODE_KIND,
    MODE_MSS_LEN,
    MODE_MSS_HI,
    MODE_MSS_LO,
    MODE_STOPPED
  } opt_mode_t;

  typedef struct packed {
    opt_mode_t   mode;
    logic [15:0] mss;
    logic [1:0]  status;
  } walk_t;

endpackage

`default_nettype wire

@@ hw/rtl/tcp_header_field_parser.sv @@
// TCP header field parser top level: byte-wide input, one result per header.
// Depends on tcphp_pkg and tcphp_opt_walk.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one segment byte per beat and accepts a beat every cycle
// while the result register is empty or being drained. A beat with
// in_segment_start set is byte 0 of a new segment and drops any partial
// header. Bytes 0-19 fill the fixed header fields; bytes from 20 up to the
// header end (data offset times 4, at least 20) walk the option list for an
// MSS option. One result beat appears the cycle after the last header byte
// is accepted; payload bytes and bytes outside a segment give no result.

module tcp_header_field_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_segment_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_source_port,
  output logic [15:0] out_destination_port,
  output logic [31:0] out_sequence_number,
  output logic [31:0] out_ack_number,
  output logic [3:0]  out_data_offset,
  output logic [5:0]  out_reserved_bits,
  output logic [5:0]  out_flag_bits,
  output logic [15:0] out_window_size,
  output logic [15:0] out_checksum_field,
  output logic [15:0] out_urgent_pointer,
  output logic [15:0] out_max_segment_size,
  output logic [1:0]  out_option_status
);
  import tcphp_pkg::*;

  logic [5:0]  byte_position_r, byte_position_nxt, pos;
  logic        segment_active_r, segment_active_nxt;
  logic [31:0] port_pair_r, port_pair_nxt, port_base;
  logic [31:0] seq_r, seq_nxt, seq_base;
  logic [31:0] ack_r, ack_nxt, ack_base;
  logic [15:0] off_flags_r, off_flags_nxt, off_flags_base;
  logic [15:0] window_r, window_nxt, window_base;
  logic [15:0] checksum_r, checksum_nxt, checksum_base;
  logic [15:0] urgent_r, urgent_nxt, urgent_base;
  walk_t       walk_r, walk_nxt, walk_base, walk_opt;

  logic        out_valid_r;
  logic [15:0] src_port_r, dst_port_r, window_out_r, checksum_out_r, urgent_out_r, mss_out_r;
  logic [31:0] seq_out_r, ack_out_r;
  logic [3:0]  offset_out_r;
  logic [5:0]  reserved_out_r, flags_out_r;
  logic [1:0]  status_out_r;

  logic       act, fire, emit, in_fixed;
  logic [5:0] hdr_len, hdr_end;

  assign in_ready = !out_valid_r || out_ready;
  assign fire     = in_valid && in_ready;
  assign act      = in_segment_start || segment_active_r;

  always_comb begin
    if (in_segment_start) begin
      pos            = '0;
      port_base      = '0;
      seq_base       = '0;
      ack_base       = '0;
      off_flags_base = '0;
      window_base    = '0;
      checksum_base  = '0;
      urgent_base    = '0;
      walk_base      = '{mode: MODE_KIND, mss: MSS_NONE, status: ST_HDR_END};
    end else begin
      pos            = byte_position_r;
      port_base      = port_pair_r;
      seq_base       = seq_r;
      ack_base       = ack_r;
      off_flags_base = off_flags_r;
      window_base    = window_r;
      checksum_base  = checksum_r;
      urgent_base    = urgent_r;
      walk_base      = walk_r;
    end
  end

  assign in_fixed = pos < HDR_FIXED_BYTES;

  // gather the fixed header big-endian
  always_comb begin
    port_pair_nxt = port_base;
    seq_nxt       = seq_base;
    ack_nxt       = ack_base;
    off_flags_nxt = off_flags_base;
    window_nxt    = window_base;
    checksum_nxt  = checksum_base;
    urgent_nxt    = urgent_base;
    if (in_fixed) begin
      if (pos < 6'd4) begin
        port_pair_nxt = {port_base[23:0], in_data_byte};
      end else if (pos < 6'd8) begin
        seq_nxt = {seq_base[23:0], in_data_byte};
      end else if (pos < 6'd12) begin
        ack_nxt = {ack_base[23:0], in_data_byte};
      end else if (pos < 6'd14) begin
        off_flags_nxt = {off_flags_base[7:0], in_data_byte};
      end else if (pos < 6'd16) begin
        window_nxt = {window_base[7:0], in_data_byte};
      end else if (pos < 6'd18) begin
        checksum_nxt = {checksum_base[7:0], in_data_byte};
      end else begin
        urgent_nxt = {urgent_base[7:0], in_data_byte};
      end
    end
  end

  assign hdr_len = {off_flags_nxt[15:12], 2'b00};
  assign hdr_end = (hdr_len < HDR_FIXED_BYTES) ? HDR_FIXED_BYTES : hdr_len;

  tcphp_opt_walk u_opt_walk (
    .cur       (walk_base),
    .data_byte (in_data_byte),
    .pos       (pos),
    .hdr_end   (hdr_end),
    .nxt       (walk_opt)
  );

  assign walk_nxt           = in_fixed ? walk_base : walk_opt;
  assign emit               = act && (({1'b0, pos} + 7'd1) >= {1'b0, hdr_end});
  assign segment_active_nxt = act && !emit;
  assign byte_position_nxt  = emit ? 6'd0 : (pos + 6'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_position_r  <= '0;
      segment_active_r <= 1'b0;
      port_pair_r      <= '0;
      seq_r            <= '0;
      ack_r            <= '0;
      off_flags_r      <= '0;
      window_r         <= '0;
      checksum_r       <= '0;
      urgent_r         <= '0;
      walk_r           <= '{mode: MODE_KIND, mss: MSS_NONE, status: ST_HDR_END};
      out_valid_r      <= 1'b0;
    end else begin
      if (fire && act) begin
        byte_position_r  <= byte_position_nxt;
        segment_active_r <= segment_active_nxt;
        port_pair_r      <= port_pair_nxt;
        seq_r            <= seq_nxt;
        ack_r            <= ack_nxt;
        off_flags_r      <= off_flags_nxt;
        window_r         <= window_nxt;
        checksum_r       <= checksum_nxt;
        urgent_r         <= urgent_nxt;
        walk_r           <= walk_nxt;
      end
      if (fire && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      src_port_r     <= port_pair_nxt[31:16];
      dst_port_r     <= port_pair_nxt[15:0];
      seq_out_r      <= seq_nxt;
      ack_out_r      <= ack_nxt;
      offset_out_r   <= off_flags_nxt[15:12];
      reserved_out_r <= {off_flags_nxt[11:8], off_flags_nxt[7:6]};
      flags_out_r    <= off_flags_nxt[5:0];
      window_out_r   <= window_nxt;
      checksum_out_r <= checksum_nxt;
      urgent_out_r   <= urgent_nxt;
      mss_out_r      <= walk_nxt.mss;
      status_out_r   <= walk_nxt.status;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_source_port      = src_port_r;
  assign out_destination_port = dst_port_r;
  assign out_sequence_number  = seq_out_r;
  assign out_ack_number       = ack_out_r;
  assign out_data_offset      = offset_out_r;
  assign out_reserved_bits    = reserved_out_r;
  assign out_flag_bits        = flags_out_r;
  assign out_window_size      = window_out_r;
  assign out_checksum_field   = checksum_out_r;
  assign out_urgent_pointer   = urgent_out_r;
  assign out_max_segment_size = mss_out_r;
  assign out_option_status    = status_out_r;

`ifndef SYNTHESIS
  a_rise_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_valid && in_ready))
    else $error("result appeared without an accepted beat");

  a_idle_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !segment_active_r |-> (byte_position_r == 6'd0))
    else $error("byte position nonzero outside a segment");

  a_pos_in_header: assert property (@(posedge clk) disable iff (!rst_n)
    byte_position_r <= 6'd59)
    else $error("byte position past longest header");

  a_status_on_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (walk_r.mode != MODE_STOPPED) |-> (walk_r.status == ST_HDR_END))
    else $error("walk status set while walk still running");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/tcphp_opt_walk.sv @@
// Option walker: next walk state for one option byte of the TCP header.
// Depends on tcphp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcphp_opt_walk (
  input  tcphp_pkg::walk_t cur,
  input  logic [7:0]       data_byte,
  input  logic [5:0]       pos,
  input  logic [5:0]       hdr_end,
  output tcphp_pkg::walk_t nxt
);
  import tcphp_pkg::*;

  logic mss_fits;

  assign mss_fits = ({1'b0, pos} + 7'd3) < {1'b0, hdr_end};

  always_comb begin
    nxt = cur;
    case (cur.mode)
      MODE_KIND: begin
        if (data_byte == KIND_END) begin
          nxt.status = ST_EOL;
          nxt.mode   = MODE_STOPPED;
        end else if (data_byte == KIND_NOP) begin
          nxt.mode = MODE_KIND;
        end else if (data_byte == KIND_MSS) begin
          if (mss_fits) begin
            nxt.mode = MODE_MSS_LEN;
          end else begin
            nxt.status = ST_MSS_TRUNC;
            nxt.mode   = MODE_STOPPED;
          end
        end else begin
          nxt.status = ST_UNKNOWN;
          nxt.mode   = MODE_STOPPED;
        end
      end
      MODE_MSS_LEN: begin
        nxt.mode = MODE_MSS_HI;
      end
      MODE_MSS_HI: begin
        nxt.mss  = {data_byte, cur.mss[7:0]};
        nxt.mode = MODE_MSS_LO;
      end
      MODE_MSS_LO: begin
        nxt.mss  = {cur.mss[15:8], data_byte};
        nxt.mode = MODE_KIND;
      end
      default: begin
        nxt.mode = MODE_STOPPED;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for tcp_header_field_parser: byte beats in, one header result out.
// Depends on tcphp_pkg and the parser RTL; a built-in predictor checks every result beat.
`timescale 1ns / 1ps

module testbench;
  import tcphp_pkg::*;

  typedef struct packed {
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] seq_num;
    logic [31:0] ack_num;
    logic [3:0]  doff;
    logic [5:0]  rsv;
    logic [5:0]  flags;
    logic [15:0] window;
    logic [15:0] csum;
    logic [15:0] urg_ptr;
    logic [15:0] mss;
    logic [1:0]  status;
  } hdr_fields_t;

  typedef struct packed {
    logic [3:0]  lead;
    logic [7:0]  fill;
    logic [3:0]  doff;
    logic [3:0]  nopt;
    logic [63:0] opts;
    logic [3:0]  pay;
    logic [5:0]  cut;
    logic        pin;
    logic [15:0] pmss;
    logic [1:0]  pstat;
  } seg_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_segment_start;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] out_source_port;
  logic [15:0] out_destination_port;
  logic [31:0] out_sequence_number;
  logic [31:0] out_ack_number;
  logic [3:0]  out_data_offset;
  logic [5:0]  out_reserved_bits;
  logic [5:0]  out_flag_bits;
  logic [15:0] out_window_size;
  logic [15:0] out_checksum_field;
  logic [15:0] out_urgent_pointer;
  logic [15:0] out_max_segment_size;
  logic [1:0]  out_option_status;

  tcp_header_field_parser u_top (.*);

  always #1 clk = ~clk;

  // predictor state
  logic [5:0]  pos;
  logic        in_hdr;
  logic [31:0] port_word;
  logic [31:0] seq_word;
  logic [31:0] ack_word;
  logic [15:0] offl_word;
  logic [15:0] win_word;
  logic [15:0] csum_word;
  logic [15:0] urg_word;
  logic [15:0] mss_word;
  opt_mode_t   walk_mode;
  logic [1:0]  walk_stat;

  hdr_fields_t pending_hdrs[$];
  logic [7:0]  opt_bytes[$];
  seg_row_t    dir_rows[14];
  int          err_count = 0;
  int          beats_sent = 0;
  int          hdrs_parsed = 0;
  int          stat_seen[4] = '{0, 0, 0, 0};
  bit          calm = 1'b0;

  task automatic parse_byte(input logic [7:0] b, input logic s, output bit got,
                            output hdr_fields_t r);
    int p;
    int hend;
    got = 1'b0;
    r = '0;
    if (s) begin
      pos = '0;
      port_word = '0;
      seq_word = '0;
      ack_word = '0;
      offl_word = '0;
      win_word = '0;
      csum_word = '0;
      urg_word = '0;
      mss_word = MSS_NONE;
      walk_mode = MODE_KIND;
      walk_stat = ST_HDR_END;
      in_hdr = 1'b1;
    end
    if (!in_hdr) return;
    p = pos;
    if (p < 4) port_word = {port_word[23:0], b};
    else if (p < 8) seq_word = {seq_word[23:0], b};
    else if (p < 12) ack_word = {ack_word[23:0], b};
    else if (p < 14) offl_word = {offl_word[7:0], b};
    else if (p < 16) win_word = {win_word[7:0], b};
    else if (p < 18) csum_word = {csum_word[7:0], b};
    else if (p < 20) urg_word = {urg_word[7:0], b};
    hend = 4 * int'(offl_word[15:12]);
    if (hend < 20) hend = 20;
    if (p >= 20) begin
      case (walk_mode)
        MODE_KIND: begin
          if (b == KIND_END) begin
            walk_stat = ST_EOL;
            walk_mode = MODE_STOPPED;
          end else if (b == KIND_NOP) begin
            walk_mode = MODE_KIND;
          end else if (b == KIND_MSS) begin
            if (p + 3 < hend) begin
              walk_mode = MODE_MSS_LEN;
            end else begin
              walk_stat = ST_MSS_TRUNC;
              walk_mode = MODE_STOPPED;
            end
          end else begin
            walk_stat = ST_UNKNOWN;
            walk_mode = MODE_STOPPED;
          end
        end
        MODE_MSS_LEN: walk_mode = MODE_MSS_HI;
        MODE_MSS_HI: begin
          mss_word[15:8] = b;
          walk_mode = MODE_MSS_LO;
        end
        MODE_MSS_LO: begin
          mss_word[7:0] = b;
          walk_mode = MODE_KIND;
        end
        default: walk_mode = MODE_STOPPED;
      endcase
    end
    if (p + 1 >= hend) begin
      in_hdr = 1'b0;
      pos = '0;
      got = 1'b1;
      r.src_port = port_word[31:16];
      r.dst_port = port_word[15:0];
      r.seq_num = seq_word;
      r.ack_num = ack_word;
      r.doff = offl_word[15:12];
      r.rsv = {offl_word[11:8], offl_word[7:6]};
      r.flags = offl_word[5:0];
      r.window = win_word;
      r.csum = csum_word;
      r.urg_ptr = urg_word;
      r.mss = mss_word;
      r.status = walk_stat;
      hdrs_parsed++;
      stat_seen[walk_stat]++;
    end else begin
      pos = 6'(p + 1);
    end
  endtask

  task automatic send_beat(input logic [7:0] b, input logic s, input bit pin,
                           input logic [15:0] pmss, input logic [1:0] pstat);
    bit          got;
    hdr_fields_t r;
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_segment_start <= s;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
    parse_byte(b, s, got, r);
    if (got) begin
      if (pin) begin
        r.mss = pmss;
        r.status = pstat;
      end
      pending_hdrs.push_back(r);
    end else if (pin) begin
      $display("%0t: header end expected %0d actual %0d", $time, 1, 0);
      err_count++;
    end
    @(negedge clk);
  endtask

  // byte 0 sits in fixed[159:152]; option area comes from opt_bytes, NOP padded
  task automatic send_segment(input logic [159:0] fixed, input int npay, input int cut,
                              input bit pin, input logic [15:0] pmss, input logic [1:0] pstat);
    int         hl;
    int         last;
    int         i;
    logic [7:0] b;
    hl = 4 * int'(fixed[63:60]);
    if (hl < 20) hl = 20;
    last = (cut > 0) ? cut : hl + npay;
    for (i = 0; i < last; i++) begin
      if (i < 20) b = fixed[159 - 8 * i -: 8];
      else if (i < hl) b = (i - 20 < opt_bytes.size()) ? opt_bytes[i - 20] : KIND_NOP;
      else b = 8'($urandom_range(0, 255));
      send_beat(b, i == 0, pin && cut == 0 && i == hl - 1, pmss, pstat);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_hdrs.size() != 0);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    hdr_fields_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_hdrs.size() == 0) begin
        $display("%0t: result beat expected none actual %0h", $time, out_source_port);
        err_count++;
      end else begin
        want = pending_hdrs.pop_front();
        check_field("source_port", want.src_port, out_source_port);
        check_field("destination_port", want.dst_port, out_destination_port);
        check_field("sequence_number", want.seq_num, out_sequence_number);
        check_field("ack_number", want.ack_num, out_ack_number);
        check_field("data_offset", want.doff, out_data_offset);
        check_field("reserved_bits", want.rsv, out_reserved_bits);
        check_field("flag_bits", want.flags, out_flag_bits);
        check_field("window_size", want.window, out_window_size);
        check_field("checksum_field", want.csum, out_checksum_field);
        check_field("urgent_pointer", want.urg_ptr, out_urgent_pointer);
        check_field("max_segment_size", want.mss, out_max_segment_size);
        check_field("option_status", want.status, out_option_status);
      end
    end
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(0, 15)) @(negedge clk);
    end
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    seg_row_t       row;
    logic [159:0]   fixed;
    logic [3:0]     doff;
    int             hl;
    int             k;
    int             cut;
    int             segs;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = '0;
    in_segment_start = 1'b0;
    in_hdr = 1'b0;
    pos = '0;

    // lead, fill, doff, nopt, option bytes, payload, cut, pinned, mss, status
    dir_rows[0]  = '{4'd2, 8'h00, 4'd5, 4'd0, 64'h0, 4'd0, 6'd0, 1'b1, MSS_NONE, ST_HDR_END};
    dir_rows[1]  = '{4'd0, 8'hFF, 4'd15, 4'd4, {KIND_MSS, 8'h04, 8'h12, 8'h34, 32'h0},
                     4'd3, 6'd0, 1'b1, 16'h1234, ST_HDR_END};
    dir_rows[2]  = '{4'd0, 8'hA5, 4'd0, 4'd0, 64'h0, 4'd1, 6'd0, 1'b1, MSS_NONE, ST_HDR_END};
    dir_rows[3]  = '{4'd0, 8'h5A, 4'd4, 4'd0, 64'h0, 4'd0, 6'd0, 1'b1, MSS_NONE, ST_HDR_END};
    dir_rows[4]  = '{4'd0, 8'h3C, 4'd6, 4'd2, {KIND_NOP, KIND_END, 48'h0},
                     4'd0, 6'd0, 1'b1, MSS_NONE, ST_EOL};
    dir_rows[5]  = '{4'd0, 8'hC3, 4'd6, 4'd2, {KIND_NOP, 8'h07, 48'h0},
                     4'd0, 6'd0, 1'b1, MSS_NONE, ST_UNKNOWN};
    dir_rows[6]  = '{4'd0, 8'h96, 4'd6, 4'd2, {KIND_NOP, KIND_MSS, 48'h0},
                     4'd0, 6'd0, 1'b1, MSS_NONE, ST_MSS_TRUNC};
    dir_rows[7]  = '{4'd0, 8'h69, 4'd6, 4'd4, {KIND_MSS, 8'h00, 8'hFF, 8'hEE, 32'h0},
                     4'd0, 6'd0, 1'b1, 16'hFFEE, ST_HDR_END};
    dir_rows[8]  = '{4'd0, 8'h0F, 4'd7, 4'd8,
                     {KIND_MSS, 8'h04, 8'h00, 8'h00, KIND_MSS, 8'h04, 8'hAB, 8'hCD},
                     4'd0, 6'd0, 1'b1, 16'hABCD, ST_HDR_END};
    dir_rows[9]  = '{4'd0, 8'h33, 4'd5, 4'd0, 64'h0, 4'd0, 6'd9, 1'b0, MSS_NONE, ST_HDR_END};
    dir_rows[10] = '{4'd0, 8'hF0, 4'd8, 4'd5, {KIND_MSS, 8'h04, 8'h05, 8'hB4, KIND_END, 24'h0},
                     4'd2, 6'd0, 1'b1, 16'h05B4, ST_EOL};
    dir_rows[11] = '{4'd0, 8'h00, 4'd15, 4'd3, {KIND_NOP, KIND_NOP, 8'hFE, 40'h0},
                     4'd0, 6'd0, 1'b1, MSS_NONE, ST_UNKNOWN};
    dir_rows[12] = '{4'd0, 8'h24, 4'd7, 4'd2, {KIND_MSS, 8'h04, 48'h0},
                     4'd0, 6'd22, 1'b0, MSS_NONE, ST_HDR_END};
    dir_rows[13] = '{4'd0, 8'h81, 4'd7, 4'd3, {KIND_NOP, KIND_NOP, KIND_MSS, 40'h0},
                     4'd0, 6'd0, 1'b0, MSS_NONE, ST_HDR_END};

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      repeat (row.lead) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0, '0, '0);
      fixed = {20{row.fill}};
      fixed[63:56] = {row.doff, row.fill[3:0]};
      opt_bytes.delete();
      for (k = 0; k < row.nopt; k++) opt_bytes.push_back(row.opts[63 - 8 * k -: 8]);
      send_segment(fixed, row.pay, row.cut, row.pin, row.pmss, row.pstat);
    end
    wait_drained();

    segs = 0;
    while (!calm || segs < 4) begin
      if (!calm && beats_sent >= 720) begin
        calm = 1'b1;
        segs = 0;
      end
      if (!calm && segs == 12) wait_drained();
      for (k = 0; k < 20; k++) fixed[159 - 8 * k -: 8] = 8'($urandom_range(0, 255));
      k = $urandom_range(0, 15);
      if (k < 2) doff = 4'($urandom_range(0, 4));
      else if (k < 13) doff = 4'($urandom_range(5, 8));
      else doff = 4'($urandom_range(9, 15));
      fixed[63:60] = doff;
      hl = (doff < 5) ? 20 : 4 * int'(doff);
      opt_bytes.delete();
      while (opt_bytes.size() < hl - 20) begin
        k = $urandom_range(0, 19);
        if (k < 6) begin
          opt_bytes.push_back(KIND_NOP);
        end else if (k < 13) begin
          opt_bytes.push_back(KIND_MSS);
          opt_bytes.push_back(8'h04);
          opt_bytes.push_back(8'($urandom_range(0, 255)));
          opt_bytes.push_back(8'($urandom_range(0, 255)));
        end else if (k < 15) begin
          opt_bytes.push_back(KIND_END);
        end else if (k < 17) begin
          opt_bytes.push_back(8'($urandom_range(3, 255)));
        end else begin
          opt_bytes.push_back(8'($urandom_range(0, 255)));
        end
      end
      cut = (!calm && $urandom_range(0, 11) == 0) ? $urandom_range(1, hl - 1) : 0;
      send_segment(fixed, $urandom_range(0, 4), cut, 1'b0, '0, '0);
      segs++;
    end

    wait_drained();
    repeat (4) @(negedge clk);
    $display("covered %0d byte beats and %0d parsed headers", beats_sent, hdrs_parsed);
    $display("walk ends: header end %0d, end of list %0d, unknown kind %0d, short MSS %0d",
             stat_seen[ST_HDR_END], stat_seen[ST_EOL], stat_seen[ST_UNKNOWN],
             stat_seen[ST_MSS_TRUNC]);
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
